// ----- rtl/lbp_3x3_code_stream_defines.svh -----
`ifndef LBP_3X3_CODE_STREAM_DEFINES_SVH
`define LBP_3X3_CODE_STREAM_DEFINES_SVH

// same-cycle implication, checked while not in reset
`define LBP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while not in reset
`define LBP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lbp_pkg.sv -----
package lbp_pkg;

   localparam int PIXEL_BITS  = 8;
   localparam int WIDTH_BITS  = 11;
   localparam int HEIGHT_BITS = 16;
   localparam int CSR_DW      = 16;
   localparam int CSR_IW      = 1;

   localparam logic [CSR_IW-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IW-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   typedef struct packed {
      logic emit;
      logic frame_end;
   } pos_flags_type;

endpackage

// ----- rtl/lbp_3x3_code_stream.sv -----
// 3x3 local binary pattern coder for a raster stream of 8-bit gray pixels.
// req channel: one pixel per word, tuser marks the first pixel of a frame.
// rsp channel: one code per interior pixel (row >= 2, column >= 2 of the
// incoming raster, centred one row and one column back); tlast marks the
// last code of the frame. Words at the first two rows or columns give no code.
// csr port: index 0 image width (clamped to 3..MAX_WIDTH), index 1 image
// height (raised to 3); write only while the stream is idle.
// Throughput is one pixel per cycle while rsp does not stall. A code passes
// the pixel stage, then the output register: the line store read (both
// previous rows sit in one word of a single-port-write, single-read memory) is
// registered with the pixel, then the eight compares feed the output register.
// When rsp stalls the output register holds its word and the pixel stage
// behind it still fills, so one more pixel is taken before req_tready drops.
// Synchronous reset clears the counters, the window and the valid flags;
// the line stores need no clearing, words read before they are written give no code.
module lbp_3x3_code_stream
   import lbp_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // pixel
   input  logic              req_tuser,   // frame_start
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // code
   output logic              rsp_tlast,   // frame_end
   input  logic              csr_wen,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

`include "lbp_3x3_code_stream_defines.svh"

   localparam int CW = $clog2(MAX_WIDTH);

   logic          req_acc, s1_adv;
   logic [CW-1:0] rd_col;
   pos_flags_type pos_flags;

   logic          s1_valid_ff;
   pixel_type     s1_pixel_ff;
   logic [CW-1:0] s1_col_ff;
   pos_flags_type s1_flags_ff;

   logic [2*PIXEL_BITS-1:0] line_rd;
   pixel_type               top, mid, code;

   logic      rsp_valid_ff, rsp_last_ff;
   pixel_type rsp_code_ff;

   assign req_acc    = req_tvalid && req_tready;
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;

   lbp_raster_ctr #(.MAX_WIDTH(MAX_WIDTH)) u_ctr (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .step        (req_acc),
      .frame_start (req_tuser),
      .col         (rd_col),
      .flags       (pos_flags)
   );

   // upper byte: row r-2, lower byte: row r-1
   lbp_line_ram #(.DEPTH(MAX_WIDTH), .WIDTH(2 * PIXEL_BITS)) u_lines (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data ({mid, s1_pixel_ff}),
      .rd_en   (req_acc),
      .rd_addr (rd_col),
      .rd_data (line_rd)
   );

   assign top = line_rd[2*PIXEL_BITS-1:PIXEL_BITS];
   assign mid = line_rd[PIXEL_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_acc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_pixel_ff <= req_tdata;
         s1_col_ff   <= rd_col;
         s1_flags_ff <= pos_flags;
      end
   end

   lbp_window u_win (
      .clock (clock),
      .reset (reset),
      .shift (s1_adv),
      .top   (top),
      .mid   (mid),
      .bot   (s1_pixel_ff),
      .code  (code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= s1_flags_ff.emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_code_ff <= code;
         rsp_last_ff <= s1_flags_ff.frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_code_ff;
   assign rsp_tlast  = rsp_last_ff;

   `LBP_ASSERT_NOW(a_stall_source, clock, reset, !req_tready,
      s1_valid_ff && rsp_valid_ff && !rsp_tready, "req stalled without a full pipe")
   `LBP_ASSERT_NEXT(a_stage_hold, clock, reset, s1_valid_ff && !s1_adv,
      s1_valid_ff && $stable(s1_col_ff) && $stable(s1_pixel_ff), "stalled pixel stage moved")
   `LBP_ASSERT_NEXT(a_frame_origin, clock, reset, req_acc && req_tuser,
      s1_valid_ff && (s1_col_ff == '0) && !s1_flags_ff.emit, "frame start not at origin")

endmodule

// ----- rtl/lbp_line_ram.sv -----
module lbp_line_ram
   import lbp_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // a write to the address being read forwards the new word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_ff <= wr_data;
         end else begin
            rd_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_ff;

endmodule

// ----- rtl/lbp_raster_ctr.sv -----
module lbp_raster_ctr
   import lbp_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wen,
   input  logic [CSR_IW-1:0]            csr_index,
   input  logic [CSR_DW-1:0]            csr_wdata,
   input  logic                         step,
   input  logic                         frame_start,
   output logic [$clog2(MAX_WIDTH)-1:0] col,
   output pos_flags_type                flags
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = ($clog2(MAX_WIDTH + 1) > WIDTH_BITS) ?
                       $clog2(MAX_WIDTH + 1) : WIDTH_BITS;

   logic [WIDTH_BITS-1:0]  width_ff;
   logic [HEIGHT_BITS-1:0] height_ff;
   logic [CW-1:0]          col_ff, col_in;
   logic [HEIGHT_BITS-1:0] row_ff, row_in;

   logic [EW-1:0]          wid_ext, wid_eff, last_col;
   logic [HEIGHT_BITS-1:0] hgt_eff, last_row;
   logic [CW-1:0]          c;
   logic [HEIGHT_BITS-1:0] r;
   logic                   end_col, end_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      wid_ext = EW'(width_ff);
      if (wid_ext < EW'(3)) begin
         wid_eff = EW'(3);
      end else if (wid_ext > EW'(MAX_WIDTH)) begin
         wid_eff = EW'(MAX_WIDTH);
      end else begin
         wid_eff = wid_ext;
      end
      last_col = wid_eff - EW'(1);
      hgt_eff  = (height_ff < HEIGHT_BITS'(3)) ? HEIGHT_BITS'(3) : height_ff;
      last_row = hgt_eff - HEIGHT_BITS'(1);

      c = frame_start ? '0 : col_ff;
      r = frame_start ? '0 : row_ff;
      end_col = (EW'(c) >= last_col);
      end_row = (r >= last_row);

      flags.emit      = (r >= HEIGHT_BITS'(2)) && (c >= CW'(2));
      flags.frame_end = end_row && end_col;

      if (end_col) begin
         col_in = '0;
         row_in = end_row ? '0 : r + HEIGHT_BITS'(1);
      end else begin
         col_in = c + CW'(1);
         row_in = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (step) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col = c;

endmodule

// ----- rtl/lbp_window.sv -----
module lbp_window
   import lbp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  pixel_type top,
   input  pixel_type mid,
   input  pixel_type bot,
   output pixel_type code
);

   // left column top, mid, bottom, then centre column top, mid, bottom
   pixel_type win_ff [6];
   pixel_type centre;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= bot;
      end
   end

   always_comb begin
      centre  = win_ff[4];
      code[7] = win_ff[0] > centre;
      code[6] = win_ff[3] > centre;
      code[5] = top > centre;
      code[4] = mid > centre;
      code[3] = bot > centre;
      code[2] = win_ff[5] > centre;
      code[1] = win_ff[2] > centre;
      code[0] = win_ff[1] > centre;
   end

endmodule

// ----- bench/tb.sv -----
module tb;
   import lbp_pkg::*;

   localparam int LINE_DEPTH   = 1024;
   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 400;
   localparam int SETTLE_CYCLES = 6;

   typedef struct packed {
      logic [7:0] code;
      logic       frame_end;
   } code_word_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = '0;
   logic              req_tuser = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;
   logic              rsp_tlast;
   logic              csr_wen = 1'b0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   lbp_3x3_code_stream dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // mirror of the coder state
   logic [7:0]        row_above  [LINE_DEPTH];
   logic [7:0]        row_above2 [LINE_DEPTH];
   logic [7:0]        win [6];
   int unsigned       col_pos;
   int unsigned       row_pos;
   logic [10:0]       width_reg;
   logic [15:0]       height_reg;

   code_word_type     code_q [$];
   code_word_type     oldest;
   int                errors;
   int                quiet_cycles;
   bit                gaps_on;
   int                run_left;
   int                stall_left;
   int                ready_pick;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned eff_width();
      if (width_reg < 3) return 3;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return 32'(width_reg);
   endfunction

   function automatic int unsigned eff_height();
      return (height_reg < 3) ? 3 : 32'(height_reg);
   endfunction

   task automatic predict_code(input logic [7:0] px, input logic fs);
      int unsigned   w;
      int unsigned   h;
      int unsigned   c;
      int unsigned   r;
      logic [7:0]    top;
      logic [7:0]    mid;
      logic [7:0]    ctr;
      code_word_type cw;
      w = eff_width();
      h = eff_height();
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      top = row_above2[c];
      mid = row_above[c];
      if (r >= 2 && c >= 2) begin
         ctr = win[4];
         cw.code = {win[0] > ctr, win[3] > ctr, top > ctr, mid > ctr,
                    px > ctr, win[5] > ctr, win[2] > ctr, win[1] > ctr};
         cw.frame_end = (r >= h - 1) && (c >= w - 1);
         code_q.push_back(cw);
      end
      row_above2[c] = mid;
      row_above[c]  = px;
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = px;
      if (c >= w - 1) begin
         col_pos = 0;
         row_pos = (r >= h - 1) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      if (errors < 40)
         $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
      errors++;
   endtask

   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] pick_pixel(input int mode, input logic [7:0] base);
      logic [1:0] lvl;
      case (mode)
         1: begin
            lvl = 2'($urandom_range(0, 3));
            case (lvl)
               2'd0: return 8'd0;
               2'd1: return 8'd255;
               2'd2: return base;
               default: return base + 8'd1;
            endcase
         end
         2: return base + 8'($urandom_range(0, 2)) - 8'd1;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_pixel(input logic [7:0] px, input logic fs);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= fs;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_code(px, fs);
   endtask

   // drain the pipe, including words that give no code
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (code_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DW-1:0] wdata, input logic [CSR_DW-1:0] hdata);
      wait_idle();
      csr_wen   <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= wdata;
      @(posedge clock);
      width_reg = wdata[10:0];
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= hdata;
      @(posedge clock);
      height_reg = hdata[15:0];
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_frame(input int w, input int h, input bit start, input int cut,
                             input int stray, output int sent);
      int         total;
      int         mode;
      logic [7:0] base;
      total = (cut > 0) ? cut : w * h;
      mode = $urandom_range(0, 2);
      base = 8'($urandom_range(0, 255));
      for (int i = 0; i < total; i++)
         send_pixel(pick_pixel(mode, base), (i == 0 && start) || (stray > 0 && i == stray));
      sent = total;
   endtask

   task automatic test_fixed_patterns();
      logic [7:0] pattern [27] = '{
         8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
         8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,
         8'd9,   8'd1,   8'd8,   8'd4,   8'd5,   8'd2,   8'd6,   8'd3,   8'd7};
      gaps_on = 1'b1;
      configure(16'd3, 16'd3);
      // counters are clear after reset, frames then follow by wrap-around
      foreach (pattern[i])
         send_pixel(pattern[i], 1'b0);
   endtask

   task automatic test_size_limits();
      int sent;
      configure(16'h0000, 16'h0002);
      send_frame(3, 3, 1'b1, 0, 0, sent);
      // one full clamped row, then a narrow width shows where the row wrapped
      configure(16'hFFFF, 16'h0001);
      send_frame(LINE_DEPTH, 3, 1'b1, LINE_DEPTH + 1, 0, sent);
      configure(16'd3, 16'd3);
      send_frame(3, 3, 1'b0, 0, 0, sent);
      configure(16'd3, 16'hFFFF);
      send_frame(3, 10, 1'b1, 0, 0, sent);
   endtask

   task automatic test_shrink_mid_frame();
      int sent;
      configure(16'd10, 16'd8);
      send_frame(10, 8, 1'b1, 38, 0, sent);
      // column and row now lie past the new last index
      configure(16'd5, 16'd3);
      send_pixel(8'($urandom_range(0, 255)), 1'b0);
      send_frame(5, 3, 1'b0, 0, 0, sent);
   endtask

   task automatic test_random_frames();
      int               items;
      int               w;
      int               h;
      int               nframes;
      int               cut;
      int               stray;
      int               sent;
      logic [CSR_DW-1:0] wdata;
      logic [CSR_DW-1:0] hdata;
      items = 0;
      while (items < RANDOM_ITEMS) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         w = ($urandom_range(0, 4) != 0) ? $urandom_range(3, 12) : $urandom_range(13, 48);
         h = $urandom_range(3, 8);
         wdata = {5'($urandom), 11'(w)};
         hdata = CSR_DW'(h);
         if (w == 3 && $urandom_range(0, 1)) wdata = CSR_DW'($urandom_range(0, 2));
         if (h == 3 && $urandom_range(0, 1)) hdata = CSR_DW'($urandom_range(0, 2));
         configure(wdata, hdata);
         nframes = $urandom_range(1, 3);
         for (int f = 0; f < nframes; f++) begin
            cut   = ($urandom_range(0, 99) < 15) ? $urandom_range(1, w * h - 1) : 0;
            stray = ($urandom_range(0, 99) < 10) ? $urandom_range(1, w * h - 1) : 0;
            send_frame(w, h, (f == 0) || $urandom_range(0, 1), cut, stray, sent);
            items += sent;
         end
      end
      wait_idle();
   endtask

   always @(posedge clock) begin
      if (run_left == 0 && stall_left == 0) begin
         ready_pick = $urandom_range(0, 99);
         if (ready_pick < 50) run_left = $urandom_range(1, 8);
         else if (ready_pick < 80) stall_left = $urandom_range(1, 3);
         else if (ready_pick < 95) run_left = $urandom_range(30, 120);
         else stall_left = $urandom_range(10, 40);
      end
      if (run_left > 0) begin
         run_left--;
         rsp_tready <= 1'b1;
      end else begin
         stall_left--;
         rsp_tready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (code_q.size() == 0) begin
            report_mismatch("unexpected code word", int'({rsp_tdata, rsp_tlast}), 0);
         end else begin
            oldest = code_q.pop_front();
            if (rsp_tdata !== oldest.code)
               report_mismatch("code", int'(rsp_tdata), int'(oldest.code));
            if (rsp_tlast !== oldest.frame_end)
               report_mismatch("frame_end", int'(rsp_tlast), int'(oldest.frame_end));
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      errors = 0;
      gaps_on = 1'b1;
      run_left = 0;
      stall_left = 0;
      col_pos = 0;
      row_pos = 0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (win[i]) win[i] = '0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
         row_above[i]  = '0;
         row_above2[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fixed_patterns();
      test_size_limits();
      test_shrink_mid_frame();
      test_random_frames();
      wait_idle();
      repeat (10) @(posedge clock);
      if (errors == 0 && code_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
